// ===== src/grb_pkg.sv =====
// ----------------------------------------------------------------------------
// grb_pkg
// shared types, constants and helpers of the gamepad report builder
// ----------------------------------------------------------------------------
package grb_pkg;

   // report layout
   localparam int REPORT_BYTES = 20;
   localparam int RPT_W        = REPORT_BYTES * 8;
   localparam int EMIT_CNT_W   = $clog2(REPORT_BYTES);

   // value path and divider
   localparam int VAL_W     = 32;
   localparam int DIV_STEPS = VAL_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // ports
   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 4;
   localparam int CSR_IDX_W   = 3;

   // rescale output ranges
   localparam logic [VAL_W-1:0] TRIG_OUT_MIN  = 32'h0000_0000;
   localparam logic [VAL_W-1:0] TRIG_OUT_MAX  = 32'h0000_00FF;
   localparam logic [VAL_W-1:0] STICK_OUT_MIN = 32'hFFFF_8000;
   localparam logic [VAL_W-1:0] STICK_OUT_MAX = 32'h0000_7FFF;

   // register reset values
   localparam logic [VAL_W-1:0] TRIG_IN_MIN_RST  = 32'h0000_0000;
   localparam logic [VAL_W-1:0] TRIG_IN_MAX_RST  = 32'h0000_00FF;
   localparam logic [VAL_W-1:0] STICK_IN_MIN_RST = 32'hFFFF_8000;
   localparam logic [VAL_W-1:0] STICK_IN_MAX_RST = 32'h0000_7FFF;

   // digital stick levels
   localparam logic [15:0] AXIS_NEG = 16'h8000;
   localparam logic [15:0] AXIS_POS = 16'h7FFF;

   // controls
   localparam logic [4:0] CTL_TRIG_L   = 5'd15;
   localparam logic [4:0] CTL_TRIG_R   = 5'd16;
   localparam logic [4:0] CTL_BTN_MAX  = 5'd18;
   localparam logic [4:0] CTL_SIDE_MAX = 5'd1;

   // bit positions in the 16-bit button word (byte 2 low, byte 3 high)
   localparam logic [3:0] BTN_UP    = 4'd0;
   localparam logic [3:0] BTN_DOWN  = 4'd1;
   localparam logic [3:0] BTN_LEFT  = 4'd2;
   localparam logic [3:0] BTN_RIGHT = 4'd3;

   typedef enum logic [3:0] {
      MODE_BUTTON   = 4'd0,
      MODE_TRIGGER  = 4'd1,
      MODE_STICK_XY = 4'd2,
      MODE_STICK_X  = 4'd3,
      MODE_STICK_Y  = 4'd4,
      MODE_DSTICK   = 4'd5,
      MODE_DPAD     = 4'd6,
      MODE_RELEASE  = 4'd7,
      MODE_SEND     = 4'd8
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIG_MIN  = 3'd0,
      CSR_TRIG_MAX  = 3'd1,
      CSR_STICK_MIN = 3'd2,
      CSR_STICK_MAX = 3'd3,
      CSR_AUTO_SEND = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_BUTTON,
      OP_TRIG,
      OP_AXIS,
      OP_STICK,
      OP_DSTICK,
      OP_DPAD,
      OP_CLEAR,
      OP_SEND
   } op_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_EXEC,
      B_WAIT_X,
      B_WAIT_Y,
      B_LOAD,
      B_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      R_IDLE,
      R_CHECK,
      R_MUL,
      R_DIV,
      R_ADD,
      R_DONE
   } rsc_state_type;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
   } dirs_type;

   typedef struct packed {
      op_type           op;
      logic             side;
      logic             axis_y;
      logic             invert;
      logic             pressed;
      logic [3:0]       btn_pos;
      dirs_type         dirs;
      logic [VAL_W-1:0] val_x;
      logic [VAL_W-1:0] val_y;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] v;
      logic [VAL_W-1:0] imin;
      logic [VAL_W-1:0] imax;
      logic [VAL_W-1:0] omin;
      logic [VAL_W-1:0] omax;
   } rsc_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] result;
   } rsc_rsp_type;

   // button control to position in the button word
   function automatic logic [3:0] btn_position(input logic [4:0] ctl);
      logic [3:0] pos;
      unique case (ctl)
         5'd0:    pos = 4'd10;
         5'd1:    pos = 4'd12;
         5'd2:    pos = 4'd13;
         5'd3:    pos = 4'd14;
         5'd4:    pos = 4'd15;
         5'd5:    pos = 4'd8;
         5'd6:    pos = 4'd9;
         5'd7:    pos = 4'd5;
         5'd8:    pos = 4'd4;
         5'd9:    pos = 4'd6;
         5'd10:   pos = 4'd7;
         5'd11:   pos = BTN_UP;
         5'd12:   pos = BTN_DOWN;
         5'd13:   pos = BTN_LEFT;
         5'd14:   pos = BTN_RIGHT;
         5'd17:   pos = 4'd6;
         5'd18:   pos = 4'd7;
         default: pos = 4'd0;
      endcase
      return pos;
   endfunction

endpackage

// ===== src/grb_front.sv =====
// ----------------------------------------------------------------------------
// grb_front
// unpacks and classifies update words into back-end commands
// ----------------------------------------------------------------------------
module grb_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [grb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [grb_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic [grb_pkg::VAL_W-1:0]        trig_min,
   input  logic [grb_pkg::VAL_W-1:0]        trig_max,
   input  logic                             q_full,
   output logic                             q_push,
   output grb_pkg::cmd_type                 q_cmd
);

   logic [4:0]                ctl;
   logic                      pressed;
   logic [grb_pkg::VAL_W-1:0] vx;
   logic [grb_pkg::VAL_W-1:0] vy;
   logic                      up, dn, lf, rt, socd;
   logic                      dn_c, lf_c, rt_c;
   logic                      side_ok;
   logic                      keep;
   logic [15:0]               dx, dy;

   assign ctl     = req_tdata[4:0];
   assign pressed = req_tdata[5];
   assign vx      = req_tdata[37:6];
   assign vy      = req_tdata[69:38];
   assign up      = req_tdata[71];
   assign dn      = req_tdata[72];
   assign lf      = req_tdata[73];
   assign rt      = req_tdata[74];
   assign socd    = req_tdata[75];

   // with socd set, up wins over down and left against right gives neutral
   assign dn_c = dn & ~(socd & up);
   assign lf_c = lf & ~(socd & rt);
   assign rt_c = rt & ~(socd & lf);

   assign side_ok = (ctl <= grb_pkg::CTL_SIDE_MAX);

   assign dx = (lf_c != rt_c) ? (lf_c ? grb_pkg::AXIS_NEG : grb_pkg::AXIS_POS) : 16'h0000;
   assign dy = (up != dn_c) ? (up ? grb_pkg::AXIS_POS : grb_pkg::AXIS_NEG) : 16'h0000;

   always_comb begin
      keep          = 1'b0;
      q_cmd.op      = grb_pkg::OP_SEND;
      q_cmd.side    = ctl[0];
      q_cmd.axis_y  = 1'b0;
      q_cmd.invert  = req_tdata[70];
      q_cmd.pressed = pressed;
      q_cmd.btn_pos = grb_pkg::btn_position(ctl);
      q_cmd.dirs    = '{up: up, down: dn_c, left: lf_c, right: rt_c};
      q_cmd.val_x   = vx;
      q_cmd.val_y   = vy;
      unique case (grb_pkg::mode_type'(req_tuser))
         grb_pkg::MODE_BUTTON: begin
            if (ctl == grb_pkg::CTL_TRIG_L || ctl == grb_pkg::CTL_TRIG_R) begin
               // trigger driven as a button, full or zero travel
               keep        = 1'b1;
               q_cmd.op    = grb_pkg::OP_TRIG;
               q_cmd.side  = (ctl == grb_pkg::CTL_TRIG_R);
               q_cmd.val_x = pressed ? trig_max : trig_min;
            end else if (ctl <= grb_pkg::CTL_BTN_MAX) begin
               keep     = 1'b1;
               q_cmd.op = grb_pkg::OP_BUTTON;
            end
         end
         grb_pkg::MODE_TRIGGER: begin
            keep     = side_ok;
            q_cmd.op = grb_pkg::OP_TRIG;
         end
         grb_pkg::MODE_STICK_XY: begin
            keep     = side_ok;
            q_cmd.op = grb_pkg::OP_STICK;
         end
         grb_pkg::MODE_STICK_X: begin
            keep     = side_ok;
            q_cmd.op = grb_pkg::OP_AXIS;
         end
         grb_pkg::MODE_STICK_Y: begin
            keep         = side_ok;
            q_cmd.op     = grb_pkg::OP_AXIS;
            q_cmd.axis_y = 1'b1;
            q_cmd.val_x  = vy;
         end
         grb_pkg::MODE_DSTICK: begin
            keep        = side_ok;
            q_cmd.op    = grb_pkg::OP_DSTICK;
            q_cmd.val_x = {16'h0000, dx};
            q_cmd.val_y = {16'h0000, dy};
         end
         grb_pkg::MODE_DPAD: begin
            keep     = 1'b1;
            q_cmd.op = grb_pkg::OP_DPAD;
         end
         grb_pkg::MODE_RELEASE: begin
            keep     = 1'b1;
            q_cmd.op = grb_pkg::OP_CLEAR;
         end
         grb_pkg::MODE_SEND: begin
            keep     = 1'b1;
            q_cmd.op = grb_pkg::OP_SEND;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_tready = ~q_full;
   assign q_push     = req_tvalid & ~q_full & keep;

endmodule

// ===== src/grb_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// grb_cmd_queue
// short fifo of classified commands between front and back end
// ----------------------------------------------------------------------------
module grb_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  grb_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output grb_pkg::cmd_type head
);

   grb_pkg::cmd_type                q_ff [grb_pkg::QUEUE_DEPTH];
   logic [grb_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [grb_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [grb_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [grb_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      grb_pkg::QUEUE_PTR_W'(grb_pkg::QUEUE_DEPTH - 1);

   assign full  = (count_ff == grb_pkg::QUEUE_CNT_W'(grb_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/grb_rescale.sv =====
// ----------------------------------------------------------------------------
// grb_rescale
// range rescale: saturate, 32x32 multiply, radix-4 restoring divide, offset
// ----------------------------------------------------------------------------
module grb_rescale (
   input  logic                 clock,
   input  logic                 reset,
   input  grb_pkg::rsc_req_type req,
   output grb_pkg::rsc_rsp_type rsp
);

   grb_pkg::rsc_state_type          state_ff, state_in;
   logic [grb_pkg::VAL_W-1:0]       v_ff, v_in;
   logic [grb_pkg::VAL_W-1:0]       imin_ff, imin_in;
   logic [grb_pkg::VAL_W-1:0]       imax_ff, imax_in;
   logic [grb_pkg::VAL_W-1:0]       omin_ff, omin_in;
   logic [grb_pkg::VAL_W-1:0]       omax_ff, omax_in;
   logic [grb_pkg::VAL_W-1:0]       quot_ff, quot_in;
   logic [grb_pkg::VAL_W-1:0]       rem_ff, rem_in;
   logic [grb_pkg::VAL_W-1:0]       res_ff, res_in;
   logic [grb_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [grb_pkg::VAL_W-1:0]       prod_lo;
   logic [grb_pkg::VAL_W:0]         s1, s2;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [grb_pkg::VAL_W:0] div_step(
      input logic [grb_pkg::VAL_W-1:0] rem,
      input logic                      din,
      input logic [grb_pkg::VAL_W-1:0] dvs
   );
      logic [grb_pkg::VAL_W:0] trial;
      logic [grb_pkg::VAL_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, dvs};
      if (!diff[grb_pkg::VAL_W]) begin
         return {1'b1, diff[grb_pkg::VAL_W-1:0]};
      end
      return {1'b0, trial[grb_pkg::VAL_W-1:0]};
   endfunction

   // after the range check: v_ff holds v-imin, omax_ff the output span,
   // imax_ff the divisor
   assign prod_lo = grb_pkg::VAL_W'(v_ff * omax_ff);
   assign s1      = div_step(rem_ff, quot_ff[grb_pkg::VAL_W-1], imax_ff);
   assign s2      = div_step(s1[grb_pkg::VAL_W-1:0], quot_ff[grb_pkg::VAL_W-2], imax_ff);

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      imin_in  = imin_ff;
      imax_in  = imax_ff;
      omin_in  = omin_ff;
      omax_in  = omax_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      if (req.start) begin
         v_in     = req.v;
         imin_in  = req.imin;
         imax_in  = req.imax;
         omin_in  = req.omin;
         omax_in  = req.omax;
         state_in = grb_pkg::R_CHECK;
      end else begin
         unique case (state_ff)
            grb_pkg::R_IDLE: state_in = grb_pkg::R_IDLE;
            grb_pkg::R_CHECK: begin
               priority if ($signed(v_ff) <= $signed(imin_ff)) begin
                  res_in   = omin_ff;
                  state_in = grb_pkg::R_DONE;
               end else if ($signed(v_ff) >= $signed(imax_ff)) begin
                  res_in   = omax_ff;
                  state_in = grb_pkg::R_DONE;
               end else if (imin_ff == omin_ff && imax_ff == omax_ff) begin
                  res_in   = v_ff;
                  state_in = grb_pkg::R_DONE;
               end else begin
                  v_in     = v_ff - imin_ff;
                  omax_in  = omax_ff - omin_ff;
                  imax_in  = imax_ff - imin_ff;
                  state_in = grb_pkg::R_MUL;
               end
            end
            grb_pkg::R_MUL: begin
               quot_in  = prod_lo;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = grb_pkg::R_DIV;
            end
            grb_pkg::R_DIV: begin
               quot_in = {quot_ff[grb_pkg::VAL_W-3:0], s1[grb_pkg::VAL_W], s2[grb_pkg::VAL_W]};
               rem_in  = s2[grb_pkg::VAL_W-1:0];
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == grb_pkg::DIV_CNT_W'(grb_pkg::DIV_STEPS - 1)) begin
                  state_in = grb_pkg::R_ADD;
               end
            end
            grb_pkg::R_ADD: begin
               res_in   = quot_ff + omin_ff;
               state_in = grb_pkg::R_DONE;
            end
            grb_pkg::R_DONE: state_in = grb_pkg::R_IDLE;
            default:         state_in = grb_pkg::R_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grb_pkg::R_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      imin_ff <= imin_in;
      imax_ff <= imax_in;
      omin_ff <= omin_in;
      omax_ff <= omax_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done   = (state_ff == grb_pkg::R_DONE);
   assign rsp.result = res_ff;

endmodule

// ===== src/grb_back.sv =====
// ----------------------------------------------------------------------------
// grb_back
// executes commands on the report state and streams the report out
// ----------------------------------------------------------------------------
module grb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  grb_pkg::cmd_type          q_head,
   output logic                      q_pop,
   input  logic [grb_pkg::VAL_W-1:0] trig_min,
   input  logic [grb_pkg::VAL_W-1:0] trig_max,
   input  logic [grb_pkg::VAL_W-1:0] stick_min,
   input  logic [grb_pkg::VAL_W-1:0] stick_max,
   input  logic                      auto_send,
   output grb_pkg::rsc_req_type      rsc_req,
   input  grb_pkg::rsc_rsp_type      rsc_rsp,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast
);

   grb_pkg::back_state_type          state_ff, state_in;
   grb_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [15:0]                      btn_ff, btn_in;
   logic [1:0][7:0]                  trig_ff, trig_in;
   logic [3:0][15:0]                 axis_ff, axis_in;
   logic [grb_pkg::RPT_W-1:0]        emit_ff, emit_in;
   logic [grb_pkg::EMIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [grb_pkg::RPT_W-1:0]        report_vec;
   logic [grb_pkg::VAL_W-1:0]        r_axis;
   logic [1:0]                       axis_sel;
   grb_pkg::back_state_type          after_fire;

   function automatic logic [grb_pkg::VAL_W-1:0] sx16(input logic [15:0] v);
      return {{(grb_pkg::VAL_W-16){v[15]}}, v};
   endfunction

   // report image: type, length, buttons, triggers, axes, zero tail
   always_comb begin
      report_vec          = '0;
      report_vec[15:8]    = 8'(grb_pkg::REPORT_BYTES);
      report_vec[31:16]   = btn_ff;
      report_vec[47:32]   = trig_ff;
      report_vec[111:48]  = axis_ff;
   end

   assign axis_sel   = {cmd_ff.side, cmd_ff.axis_y};
   assign r_axis     = cmd_ff.invert ? sx16(~rsc_rsp.result[15:0]) : rsc_rsp.result;
   assign after_fire = auto_send ? grb_pkg::B_LOAD : grb_pkg::B_IDLE;

   always_comb begin
      // second pass of a stick pair rescales y
      rsc_req.v = (state_ff == grb_pkg::B_WAIT_X) ? cmd_ff.val_y : cmd_ff.val_x;
      if (cmd_ff.op == grb_pkg::OP_TRIG) begin
         rsc_req.imin = trig_min;
         rsc_req.imax = trig_max;
         rsc_req.omin = grb_pkg::TRIG_OUT_MIN;
         rsc_req.omax = grb_pkg::TRIG_OUT_MAX;
      end else begin
         rsc_req.imin = stick_min;
         rsc_req.imax = stick_max;
         rsc_req.omin = grb_pkg::STICK_OUT_MIN;
         rsc_req.omax = grb_pkg::STICK_OUT_MAX;
      end
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      btn_in        = btn_ff;
      trig_in       = trig_ff;
      axis_in       = axis_ff;
      emit_in       = emit_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      rsc_req.start = 1'b0;
      unique case (state_ff)
         grb_pkg::B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = grb_pkg::B_EXEC;
            end
         end
         grb_pkg::B_EXEC: begin
            unique case (cmd_ff.op)
               grb_pkg::OP_BUTTON: begin
                  btn_in[cmd_ff.btn_pos] = cmd_ff.pressed;
                  state_in = (btn_ff[cmd_ff.btn_pos] != cmd_ff.pressed) ?
                             after_fire : grb_pkg::B_IDLE;
               end
               grb_pkg::OP_TRIG, grb_pkg::OP_AXIS, grb_pkg::OP_STICK: begin
                  rsc_req.start = 1'b1;
                  state_in      = grb_pkg::B_WAIT_X;
               end
               grb_pkg::OP_DSTICK: begin
                  axis_in[{cmd_ff.side, 1'b0}] = cmd_ff.val_x[15:0];
                  axis_in[{cmd_ff.side, 1'b1}] = cmd_ff.val_y[15:0];
                  state_in = after_fire;
               end
               grb_pkg::OP_DPAD: begin
                  btn_in[grb_pkg::BTN_UP]    = cmd_ff.dirs.up;
                  btn_in[grb_pkg::BTN_DOWN]  = cmd_ff.dirs.down;
                  btn_in[grb_pkg::BTN_LEFT]  = cmd_ff.dirs.left;
                  btn_in[grb_pkg::BTN_RIGHT] = cmd_ff.dirs.right;
                  state_in = after_fire;
               end
               grb_pkg::OP_CLEAR: begin
                  btn_in   = '0;
                  trig_in  = '0;
                  axis_in  = '0;
                  state_in = after_fire;
               end
               grb_pkg::OP_SEND: state_in = grb_pkg::B_LOAD;
               default:          state_in = grb_pkg::B_IDLE;
            endcase
         end
         grb_pkg::B_WAIT_X: begin
            if (rsc_rsp.done) begin
               unique case (cmd_ff.op)
                  grb_pkg::OP_TRIG: begin
                     // a wrapped result above 255 still counts as a change
                     if (rsc_rsp.result != {24'h000000, trig_ff[cmd_ff.side]}) begin
                        trig_in[cmd_ff.side] = rsc_rsp.result[7:0];
                        state_in = after_fire;
                     end else begin
                        state_in = grb_pkg::B_IDLE;
                     end
                  end
                  grb_pkg::OP_AXIS: begin
                     if (sx16(axis_ff[axis_sel]) != r_axis) begin
                        axis_in[axis_sel] = r_axis[15:0];
                        state_in = after_fire;
                     end else begin
                        state_in = grb_pkg::B_IDLE;
                     end
                  end
                  grb_pkg::OP_STICK: begin
                     axis_in[{cmd_ff.side, 1'b0}] = rsc_rsp.result[15:0];
                     rsc_req.start = 1'b1;
                     state_in      = grb_pkg::B_WAIT_Y;
                  end
                  default: state_in = grb_pkg::B_IDLE;
               endcase
            end
         end
         grb_pkg::B_WAIT_Y: begin
            if (rsc_rsp.done) begin
               axis_in[{cmd_ff.side, 1'b1}] = rsc_rsp.result[15:0];
               state_in = after_fire;
            end
         end
         grb_pkg::B_LOAD: begin
            emit_in  = report_vec;
            cnt_in   = '0;
            state_in = grb_pkg::B_EMIT;
         end
         grb_pkg::B_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = emit_ff[7:0];
               rsp_last_in  = (cnt_ff == grb_pkg::EMIT_CNT_W'(grb_pkg::REPORT_BYTES - 1));
               emit_in      = emit_ff >> 8;
               cnt_in       = cnt_ff + 1'b1;
               if (rsp_last_in) begin
                  state_in = grb_pkg::B_IDLE;
               end
            end
         end
         default: state_in = grb_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grb_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
         btn_ff       <= '0;
         trig_ff      <= '0;
         axis_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         btn_ff       <= btn_in;
         trig_ff      <= trig_in;
         axis_ff      <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      emit_ff     <= emit_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/gamepad_report_builder.sv =====
// ----------------------------------------------------------------------------
// gamepad_report_builder
// keeps a 20-byte gamepad input report and streams it out on request
// ----------------------------------------------------------------------------
// each request word is one update (button, trigger, stick pair, single axis,
// digital stick, dpad, release all, send); a send, or any update that fires
// while auto_send is set, streams the whole report one byte per word with
// tlast on the final byte. words are classified at the input and held in a
// two-entry command queue, so the input keeps taking words while the back
// end works or the report waits on rsp_tready, until the queue is full.
// trigger and single-axis updates take one pass through the shared rescale
// unit (range check, one 32x32 multiply, 16 radix-4 divide steps, offset
// add) and a stick pair two; button, dpad, digital stick and release
// updates do not use it. the report stream pauses on any output stall.
// unused or malformed updates are dropped at the input and produce no bytes.
// ----------------------------------------------------------------------------
module gamepad_report_builder (
   input  logic                             clock,
   input  logic                             reset,
   // request words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // control[4:0], pressed[5], value_x[37:6], value_y[69:38], invert[70],
   // dir_up[71], dir_down[72], dir_left[73], dir_right[74], socd_clean[75],
   // zero pad[79:76]
   input  logic [grb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode[3:0]
   input  logic [grb_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // report bytes
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // report_byte[7:0]
   output logic [7:0]                       rsp_tdata,
   // last_byte
   output logic                             rsp_tlast,
   // register writes
   input  logic                             csr_wr_en,
   input  logic [grb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [grb_pkg::VAL_W-1:0]        csr_wdata
);

   // range and send registers
   logic [grb_pkg::VAL_W-1:0] trig_min_ff, trig_min_in;
   logic [grb_pkg::VAL_W-1:0] trig_max_ff, trig_max_in;
   logic [grb_pkg::VAL_W-1:0] stick_min_ff, stick_min_in;
   logic [grb_pkg::VAL_W-1:0] stick_max_ff, stick_max_in;
   logic                      auto_send_ff, auto_send_in;

   // front to queue to back
   logic                      q_push;
   grb_pkg::cmd_type          q_cmd;
   logic                      q_full;
   logic                      q_pop;
   logic                      q_empty;
   grb_pkg::cmd_type          q_head;

   // back end to rescale unit
   grb_pkg::rsc_req_type      rsc_req;
   grb_pkg::rsc_rsp_type      rsc_rsp;

   // register writes, unknown indexes ignored
   always_comb begin
      trig_min_in  = trig_min_ff;
      trig_max_in  = trig_max_ff;
      stick_min_in = stick_min_ff;
      stick_max_in = stick_max_ff;
      auto_send_in = auto_send_ff;
      if (csr_wr_en) begin
         unique case (grb_pkg::csr_index_type'(csr_index))
            grb_pkg::CSR_TRIG_MIN:  trig_min_in  = csr_wdata;
            grb_pkg::CSR_TRIG_MAX:  trig_max_in  = csr_wdata;
            grb_pkg::CSR_STICK_MIN: stick_min_in = csr_wdata;
            grb_pkg::CSR_STICK_MAX: stick_max_in = csr_wdata;
            grb_pkg::CSR_AUTO_SEND: auto_send_in = csr_wdata[0];
            default:                auto_send_in = auto_send_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_min_ff  <= grb_pkg::TRIG_IN_MIN_RST;
         trig_max_ff  <= grb_pkg::TRIG_IN_MAX_RST;
         stick_min_ff <= grb_pkg::STICK_IN_MIN_RST;
         stick_max_ff <= grb_pkg::STICK_IN_MAX_RST;
         auto_send_ff <= 1'b0;
      end else begin
         trig_min_ff  <= trig_min_in;
         trig_max_ff  <= trig_max_in;
         stick_min_ff <= stick_min_in;
         stick_max_ff <= stick_max_in;
         auto_send_ff <= auto_send_in;
      end
   end

   // classify incoming words
   grb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .trig_min   (trig_min_ff),
      .trig_max   (trig_max_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   // decouples classification from execution
   grb_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   // shared multicycle rescale
   grb_rescale u_rescale (
      .clock (clock),
      .reset (reset),
      .req   (rsc_req),
      .rsp   (rsc_rsp)
   );

   // report state, update sequencing and byte streaming
   grb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .trig_min   (trig_min_ff),
      .trig_max   (trig_max_ff),
      .stick_min  (stick_min_ff),
      .stick_max  (stick_max_ff),
      .auto_send  (auto_send_ff),
      .rsc_req    (rsc_req),
      .rsc_rsp    (rsc_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/grb_checker.sv =====
// ----------------------------------------------------------------------------
// grb_checker
// port-level checks on the report byte stream
// ----------------------------------------------------------------------------
module grb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic                           rsp_acc;
   logic [grb_pkg::EMIT_CNT_W-1:0] cnt_ff, cnt_in;

   assign rsp_acc = rsp_tvalid & rsp_tready;

   // byte position inside the current report
   always_comb begin
      cnt_in = cnt_ff;
      if (rsp_acc) begin
         cnt_in = rsp_tlast ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("report byte changed while stalled");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (rsp_tlast == (cnt_ff == grb_pkg::EMIT_CNT_W'(grb_pkg::REPORT_BYTES - 1))))
      else $error("tlast not on the final report byte");

   a_type: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && cnt_ff == '0 |-> rsp_tdata == 8'h00)
      else $error("report type byte not zero");

   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && cnt_ff == grb_pkg::EMIT_CNT_W'(1) |-> rsp_tdata == 8'(grb_pkg::REPORT_BYTES))
      else $error("report length byte wrong");

   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("report stream valid after reset");

endmodule

bind gamepad_report_builder grb_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/gamepad_report_builder_tb.sv =====
// ----------------------------------------------------------------------------
// gamepad_report_builder_tb
// self-checking bench for the gamepad report builder
// ----------------------------------------------------------------------------
// a shadow copy of the 20-byte report is updated on every request word the
// block takes. sends, and effective updates while auto_send is set, queue the
// whole report as expected bytes that are checked against rsp_tdata and
// rsp_tlast. a directed opener covers every mode, control extremes, socd
// cleaning and ignored words. randomized phases follow under several range
// settings, including full-range, inverted and random ranges, with bursty
// request traffic, patterned output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module gamepad_report_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import grb_pkg::*;

   // bench timing
   localparam int SETTLE_CYCLES = 150;   // drain time for updates that emit nothing
   localparam int HOLD_CYCLES   = 400;   // long output hold-off
   localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake before giving up
   localparam int PRINT_LIMIT   = 50;

   // report layout
   localparam int BUTTON_BYTE = 2;
   localparam int TRIG_BYTE   = 4;
   localparam int STICK_BYTE  = 6;

   // controls used by name in the directed part
   localparam logic [4:0] CTL_LOGO       = 5'd0;
   localparam logic [4:0] CTL_A          = 5'd1;
   localparam logic [4:0] CTL_DPAD_RIGHT = 5'd14;
   localparam logic [4:0] CTL_L3_ALT     = 5'd17;
   localparam logic [4:0] CTL_R3_ALT     = 5'd18;
   localparam logic [4:0] CTL_FIRST_BAD  = 5'd19;
   localparam logic [4:0] CTL_LAST_BAD   = 5'd31;
   localparam logic [4:0] SIDE_LEFT      = 5'd0;
   localparam logic [4:0] SIDE_RIGHT     = 5'd1;
   localparam logic [3:0] MODE_FIRST_BAD = 4'd9;
   localparam logic [3:0] MODE_LAST_BAD  = 4'd15;

   // direction sets {up, down, left, right}
   localparam logic [3:0] DIR_NONE = 4'b0000;
   localparam logic [3:0] DIR_ALL  = 4'b1111;
   localparam logic [3:0] DIR_UDL  = 4'b1110;
   localparam logic [3:0] DIR_UL   = 4'b1010;

   // bit position in the button word (byte 2 low, byte 3 high), control 18 first
   localparam logic [18:0][3:0] BTN_SLOT = {
      4'd7, 4'd6, 4'd0, 4'd0, 4'd3, 4'd2, 4'd1, 4'd0, 4'd7, 4'd6,
      4'd4, 4'd5, 4'd9, 4'd8, 4'd15, 4'd14, 4'd13, 4'd12, 4'd10};

   typedef struct packed {
      logic [3:0]  mode;
      logic [4:0]  ctl;
      logic        pressed;
      logic [31:0] vx;
      logic [31:0] vy;
      logic        inv;
      logic        up;
      logic        dn;
      logic        lf;
      logic        rt;
      logic        socd;
   } update_word_type;

   typedef enum logic [1:0] {RX_STEADY, RX_SPARSE, RX_EVERY_THIRD, RX_COIN} rx_pattern_type;

   // dut ports; the inputs driven here are known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_TRIG_MIN;
   logic [VAL_W-1:0]       csr_wdata  = '0;

   // shadow report and register copies
   logic [7:0]  shadow_report [REPORT_BYTES];
   logic [31:0] trig_min, trig_max, stick_min, stick_max;
   logic        auto_tx;

   // stimulus and expected bytes ({last, byte})
   update_word_type pending_words[$];
   logic [8:0]      report_bytes_due[$];
   update_word_type on_bus;
   logic            word_taken = 1'b0;
   logic [8:0]      due;

   int mismatches   = 0;
   int byte_slot    = 0;
   int quiet_cycles = 0;
   int burst_left   = 1;
   int gap_left     = 0;
   int holds_asked  = 0;
   int holds_served = 0;
   int hold_left    = 0;
   int pattern_left = 0;
   int rx_tick      = 0;
   rx_pattern_type rx_pattern = RX_STEADY;

   gamepad_report_builder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // shadow model of the report
   // ------------------------------------------------------------------------

   function automatic logic [31:0] sext16(logic [31:0] v);
      return {{16{v[15]}}, v[15:0]};
   endfunction

   // clamp, then (v-imin)*(omax-omin)/(imax-imin)+omin with 32-bit wrap
   function automatic logic [31:0] scale(logic [31:0] v, logic [31:0] imin,
                                         logic [31:0] imax, logic [31:0] omin,
                                         logic [31:0] omax);
      logic [63:0] prod;
      if ($signed(v) <= $signed(imin)) return omin;
      if ($signed(v) >= $signed(imax)) return omax;
      if (imin == omin && imax == omax) return v;
      prod = {32'b0, v - imin} * {32'b0, omax - omin};
      return prod[31:0] / (imax - imin) + omin;
   endfunction

   function automatic logic [31:0] axis_value(int lo);
      return sext16({16'b0, shadow_report[lo+1], shadow_report[lo]});
   endfunction

   function automatic void put_axis(int lo, logic [31:0] v);
      shadow_report[lo]   = v[7:0];
      shadow_report[lo+1] = v[15:8];
   endfunction

   // returns 1 when the trigger byte changed
   function automatic logic set_trigger(logic side, logic [31:0] raw);
      logic [31:0] r;
      r = scale(raw, trig_min, trig_max, TRIG_OUT_MIN, TRIG_OUT_MAX);
      if (r == {24'b0, shadow_report[TRIG_BYTE+side]}) return 1'b0;
      shadow_report[TRIG_BYTE+side] = r[7:0];
      return 1'b1;
   endfunction

   // returns 1 when the button (or trigger used as a button) changed
   function automatic logic set_button(logic [4:0] ctl, logic on);
      logic [15:0] btns;
      if (ctl > CTL_BTN_MAX) return 1'b0;
      if (ctl == CTL_TRIG_L || ctl == CTL_TRIG_R)
         return set_trigger(ctl == CTL_TRIG_R, on ? trig_max : trig_min);
      btns = {shadow_report[BUTTON_BYTE+1], shadow_report[BUTTON_BYTE]};
      if (btns[BTN_SLOT[ctl]] == on) return 1'b0;
      btns[BTN_SLOT[ctl]] = on;
      {shadow_report[BUTTON_BYTE+1], shadow_report[BUTTON_BYTE]} = btns;
      return 1'b1;
   endfunction

   function automatic void queue_report();
      for (int k = 0; k < REPORT_BYTES; k++)
         report_bytes_due.push_back({k == REPORT_BYTES - 1, shadow_report[k]});
   endfunction

   // applies one accepted word to the shadow report and queues any bytes it causes
   function automatic void apply_update(update_word_type w);
      logic [31:0] r, x, y;
      logic [15:0] btns;
      logic        fire, up, dn, lf, rt;
      int          lo;
      fire = 1'b0;
      up = w.up;
      dn = w.dn;
      lf = w.lf;
      rt = w.rt;
      // socd: up wins over down, left plus right is neutral
      if ((w.mode == MODE_DSTICK || w.mode == MODE_DPAD) && w.socd) begin
         if (up && dn) dn = 1'b0;
         if (lf && rt) begin
            lf = 1'b0;
            rt = 1'b0;
         end
      end
      lo = STICK_BYTE + 4 * w.ctl[0];
      case (w.mode)
         MODE_BUTTON: begin
            fire = set_button(w.ctl, w.pressed);
         end
         MODE_TRIGGER: begin
            if (w.ctl <= CTL_SIDE_MAX) fire = set_trigger(w.ctl[0], w.vx);
         end
         MODE_STICK_XY: begin
            if (w.ctl <= CTL_SIDE_MAX) begin
               put_axis(lo, scale(w.vx, stick_min, stick_max, STICK_OUT_MIN, STICK_OUT_MAX));
               put_axis(lo + 2, scale(w.vy, stick_min, stick_max, STICK_OUT_MIN, STICK_OUT_MAX));
               fire = 1'b1;
            end
         end
         MODE_STICK_X, MODE_STICK_Y: begin
            if (w.ctl <= CTL_SIDE_MAX) begin
               if (w.mode == MODE_STICK_Y) lo = lo + 2;
               r = scale(w.mode == MODE_STICK_X ? w.vx : w.vy, stick_min, stick_max,
                         STICK_OUT_MIN, STICK_OUT_MAX);
               if (w.inv) r = sext16(~r);
               // an out-of-int16 result never matches and always writes
               if (axis_value(lo) != r) begin
                  put_axis(lo, r);
                  fire = 1'b1;
               end
            end
         end
         MODE_DSTICK: begin
            if (w.ctl <= CTL_SIDE_MAX) begin
               x = '0;
               y = '0;
               if (lf != rt) x = {16'b0, lf ? AXIS_NEG : AXIS_POS};
               if (up != dn) y = {16'b0, up ? AXIS_POS : AXIS_NEG};
               put_axis(lo, x);
               put_axis(lo + 2, y);
               fire = 1'b1;
            end
         end
         MODE_DPAD: begin
            btns = {shadow_report[BUTTON_BYTE+1], shadow_report[BUTTON_BYTE]};
            btns[BTN_UP]    = up;
            btns[BTN_DOWN]  = dn;
            btns[BTN_LEFT]  = lf;
            btns[BTN_RIGHT] = rt;
            {shadow_report[BUTTON_BYTE+1], shadow_report[BUTTON_BYTE]} = btns;
            fire = 1'b1;
         end
         MODE_RELEASE: begin
            for (int k = BUTTON_BYTE; k < REPORT_BYTES; k++) shadow_report[k] = 8'h00;
            fire = 1'b1;
         end
         MODE_SEND: begin
            queue_report();
         end
         default: ;  // unknown modes are dropped
      endcase
      if (fire && auto_tx) queue_report();
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic update_word_type mk_update(logic [3:0] mode, logic [4:0] ctl,
                                                 logic pressed, logic [31:0] vx,
                                                 logic [31:0] vy, logic inv,
                                                 logic [3:0] dirs, logic socd);
      update_word_type w;
      w.mode    = mode;
      w.ctl     = ctl;
      w.pressed = pressed;
      w.vx      = vx;
      w.vy      = vy;
      w.inv     = inv;
      {w.up, w.dn, w.lf, w.rt} = dirs;
      w.socd    = socd;
      return w;
   endfunction

   // raw value: often inside the range, otherwise at or past its ends, random or extreme
   function automatic logic [31:0] pick_raw(logic [31:0] lo, logic [31:0] hi);
      case ($urandom_range(0, 9))
         0: return lo;
         1: return hi;
         2: return lo - 1;
         3: return hi + 1;
         4: return $urandom;
         5: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: begin
            if ($signed(hi) > $signed(lo)) return lo + $urandom_range(hi - lo, 0);
            return $urandom;
         end
      endcase
   endfunction

   function automatic update_word_type random_update();
      update_word_type w;
      w = mk_update(MODE_SEND, '0, $urandom_range(0, 1), '0, '0, $urandom_range(0, 1),
                    $urandom_range(0, 15), $urandom_range(0, 1));
      if ($urandom_range(0, 99) < 5) w.mode = $urandom_range(MODE_FIRST_BAD, MODE_LAST_BAD);
      else w.mode = $urandom_range(MODE_BUTTON, MODE_SEND);
      if ($urandom_range(0, 9) == 0) w.ctl = $urandom_range(0, CTL_LAST_BAD);
      else if (w.mode == MODE_BUTTON) w.ctl = $urandom_range(0, CTL_BTN_MAX);
      else w.ctl = $urandom_range(0, CTL_SIDE_MAX);
      w.vx = (w.mode == MODE_TRIGGER) ? pick_raw(trig_min, trig_max)
                                      : pick_raw(stick_min, stick_max);
      w.vy = pick_raw(stick_min, stick_max);
      return w;
   endfunction

   task automatic note_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // register write; the block is idle whenever this is called
   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TRIG_MIN:  trig_min  = val;
         CSR_TRIG_MAX:  trig_max  = val;
         CSR_STICK_MIN: stick_min = val;
         CSR_STICK_MAX: stick_max = val;
         CSR_AUTO_SEND: auto_tx   = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_ranges(logic [31:0] tmin, logic [31:0] tmax, logic [31:0] smin,
                             logic [31:0] smax, logic autos);
      write_reg(CSR_TRIG_MIN, tmin);
      write_reg(CSR_TRIG_MAX, tmax);
      write_reg(CSR_STICK_MIN, smin);
      write_reg(CSR_STICK_MAX, smax);
      write_reg(CSR_AUTO_SEND, {31'b0, autos});
   endtask

   // sender pauses until every queued word went in and every byte came out,
   // then waits out updates that are still in flight but emit nothing
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_tvalid || report_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_random(int count);
      repeat (count) pending_words.push_back(random_update());
   endtask

   // ------------------------------------------------------------------------
   // request driver: bursts of words with random gaps, changes on falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || word_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            on_bus = pending_words.pop_front();
            req_tuser  <= on_bus.mode;
            req_tdata  <= {4'b0, on_bus.socd, on_bus.rt, on_bus.lf, on_bus.dn, on_bus.up,
                           on_bus.inv, on_bus.vy, on_bus.vx, on_bus.pressed, on_bus.ctl};
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               // next burst; a quarter of them follow back to back
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // report receiver: stall patterns of random length, plus long hold-offs
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            rx_pattern   = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 96);
         end
         pattern_left--;
         rx_tick++;
         case (rx_pattern)
            RX_STEADY:      rsp_tready <= 1'b1;
            RX_SPARSE:      rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_EVERY_THIRD: rsp_tready <= (rx_tick % 3 == 0);
            default:        rsp_tready <= $urandom_range(0, 1);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks report bytes, feeds accepted words to the shadow model
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      word_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (report_bytes_due.size() == 0) begin
               note_mismatch($sformatf("unexpected report word %02h last %0b",
                                       rsp_tdata, rsp_tlast));
            end else begin
               due = report_bytes_due.pop_front();
               if (rsp_tdata !== due[7:0])
                  note_mismatch($sformatf("report byte %0d is %02h, want %02h",
                                          byte_slot, rsp_tdata, due[7:0]));
               if (rsp_tlast !== due[8])
                  note_mismatch($sformatf("report byte %0d tlast is %0b, want %0b",
                                          byte_slot, rsp_tlast, due[8]));
            end
            byte_slot = (rsp_tlast === 1'b1) ? 0 : byte_slot + 1;
         end
         if (req_tvalid && req_tready) begin
            word_taken = 1'b1;
            apply_update(on_bus);
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      // shadow state after reset
      for (int k = 0; k < REPORT_BYTES; k++) shadow_report[k] = 8'h00;
      shadow_report[1] = REPORT_BYTES[7:0];
      trig_min  = TRIG_IN_MIN_RST;
      trig_max  = TRIG_IN_MAX_RST;
      stick_min = STICK_IN_MIN_RST;
      stick_max = STICK_IN_MAX_RST;
      auto_tx   = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opener at the reset ranges, explicit sends only
      set_ranges(TRIG_IN_MIN_RST, TRIG_IN_MAX_RST, STICK_IN_MIN_RST, STICK_IN_MAX_RST, 1'b0);
      pending_words.push_back(mk_update(MODE_SEND, '0, 0, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_A, 1, '0, '0, 0, DIR_NONE, 0));
      // same state again: no change
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_A, 1, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_LOGO, 1, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_DPAD_RIGHT, 1, '0, '0, 0,
                                        DIR_NONE, 0));
      // stick clicks through their alias controls
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_L3_ALT, 1, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_R3_ALT, 1, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_FIRST_BAD, 1, '0, '0, 0,
                                        DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_LAST_BAD, 1, '0, '0, 0,
                                        DIR_NONE, 0));
      // triggers as buttons
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_TRIG_L, 1, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_BUTTON, CTL_TRIG_R, 0, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_TRIGGER, SIDE_LEFT, 0, 32'd100, '0, 0,
                                        DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_TRIGGER, SIDE_RIGHT, 0, 32'h7FFF_FFFF, '0, 0,
                                        DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_TRIGGER, CTL_LAST_BAD, 0, 32'h8000_0000, '0, 0,
                                        DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_SEND, '0, 0, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_STICK_XY, SIDE_LEFT, 0, 32'h7FFF_FFFF,
                                        32'h8000_0000, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_STICK_XY, SIDE_RIGHT, 0, 32'd1000, -1000, 0,
                                        DIR_NONE, 0));
      // inverted single axis: zero becomes -1
      pending_words.push_back(mk_update(MODE_STICK_X, SIDE_LEFT, 0, '0, '0, 1, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_STICK_Y, SIDE_RIGHT, 0, '0, 32'd32767, 0,
                                        DIR_NONE, 0));
      // digital stick and dpad with and without socd cleaning
      pending_words.push_back(mk_update(MODE_DSTICK, SIDE_LEFT, 0, '0, '0, 0, DIR_ALL, 1));
      pending_words.push_back(mk_update(MODE_DSTICK, SIDE_RIGHT, 0, '0, '0, 0, DIR_UL, 0));
      pending_words.push_back(mk_update(MODE_DPAD, '0, 0, '0, '0, 0, DIR_UDL, 1));
      pending_words.push_back(mk_update(MODE_DPAD, '0, 0, '0, '0, 0, DIR_ALL, 0));
      pending_words.push_back(mk_update(MODE_SEND, '0, 0, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_RELEASE, '0, 0, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_FIRST_BAD, '0, 0, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_LAST_BAD, '0, 0, '0, '0, 0, DIR_NONE, 0));
      pending_words.push_back(mk_update(MODE_SEND, '0, 0, '0, '0, 0, DIR_NONE, 0));
      wait_idle();

      // widest signed ranges, auto send on
      set_ranges(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      push_random(30);
      wait_idle();

      // narrow ranges; receiver holds off while sends pile up at the input
      set_ranges(32'd0, 32'd1023, -512, 32'd511, 1'b1);
      holds_asked++;
      repeat (14) pending_words.push_back(mk_update(MODE_SEND, '0, 0, '0, '0, 0, DIR_NONE, 0));
      push_random(16);
      wait_idle();

      // empty and reversed ranges: every value saturates
      set_ranges(32'd100, 32'd100, 32'd5, -5, 1'b1);
      push_random(25);
      wait_idle();

      // random moderate ranges, random auto send
      set_ranges(-$urandom_range(0, 1000), $urandom_range(1, 5000),
                 -$urandom_range(0, 100000), $urandom_range(1, 100000),
                 $urandom_range(0, 1));
      push_random(25);
      wait_idle();

      // fully random ranges
      set_ranges($urandom, $urandom, $urandom, $urandom, 1'b1);
      push_random(25);
      wait_idle();

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
